[hdl/uks_pkg.sv]
// uks_pkg: shared types and constants for the unique key stack
// command and status codes, state encoding and default depth
// no dependencies
package uks_pkg;

  localparam int KEY_W     = 32;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 7;
  localparam int UKS_DEPTH = 64;

  typedef logic [CMD_W-1:0]         cmd_t;
  typedef logic [STATUS_W-1:0]      status_t;
  typedef logic signed [KEY_W-1:0]  key_t;
  typedef logic [COUNT_W-1:0]       count_t;

  localparam cmd_t CMD_PUSH   = 2'd0;
  localparam cmd_t CMD_POP    = 2'd1;
  localparam cmd_t CMD_SEARCH = 2'd2;

  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_FULL  = 2'd1;
  localparam status_t STAT_DUP   = 2'd2;
  localparam status_t STAT_EMPTY = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_POP,
    S_RESP
  } state_t;

endpackage

[hdl/uks_if.sv]
// uks_in_if and uks_out_if: valid/ready channels of the unique key stack
// depends on uks_pkg for field types
interface uks_in_if;
  import uks_pkg::*;

  logic valid;
  logic ready;
  cmd_t cmd;
  key_t key;

  modport source (output valid, output cmd, output key, input ready);
  modport sink (input valid, input cmd, input key, output ready);
endinterface

interface uks_out_if;
  import uks_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  key_t    key_out;
  logic    found;
  count_t  count;
  logic    is_full;
  logic    is_empty;

  modport source (output valid, output status, output key_out, output found, output count,
                  output is_full, output is_empty, input ready);
  modport sink (input valid, input status, input key_out, input found, input count,
                input is_full, input is_empty, output ready);
endinterface

[hdl/unique_key_stack.sv]
// unique_key_stack: LIFO key stack with duplicate rejection in one key memory
// push and search scan stored keys one a cycle through the memory read port
// depends on uks_pkg, uks_in_if and uks_out_if
// one item in flight; the next transfer is taken once the result is in the output register
// the scan reads one memory entry a cycle, so push and search take longer the more keys are stored
// reset: synchronous active-low rst_n empties the stack; key memory is not cleared
module unique_key_stack #(
  parameter int STACK_DEPTH = uks_pkg::UKS_DEPTH
) (
  input logic      clk,
  input logic      rst_n,
  uks_in_if.sink   in_if,
  uks_out_if.source out_if
);
  import uks_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;

  key_t mem [STACK_DEPTH];

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  cmd_t          cmd_r, cmd_nxt;
  key_t          key_r, key_nxt;
  key_t          rd_data_r;
  status_t       res_status_r, res_status_nxt;
  key_t          res_key_r, res_key_nxt;
  logic          res_found_r, res_found_nxt;

  logic          out_valid_r, out_valid_nxt;
  status_t       out_status_r, out_status_nxt;
  key_t          out_key_r, out_key_nxt;
  logic          out_found_r, out_found_nxt;
  count_t        out_count_r, out_count_nxt;
  logic          out_full_r, out_full_nxt;
  logic          out_empty_r, out_empty_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  key_t          wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  logic          in_xfer;
  logic          out_free;
  logic          full;
  logic          empty;
  logic          hit;
  logic          last;
  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] addr_ext;
  logic [XW-1:0] cnt_x;

  assign in_if.ready = (state_r == S_IDLE);
  assign in_xfer     = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;
  assign full        = (cnt_r == CW'(STACK_DEPTH));
  assign empty       = (cnt_r == '0);
  assign cnt_m1      = cnt_r - CW'(1);
  assign addr_ext    = CW'(addr_r);
  assign hit         = (rd_data_r == key_r);
  assign last        = ((addr_ext + CW'(1)) == cnt_r);
  assign cnt_x       = XW'(cnt_r);
  assign wr_addr     = cnt_r[AW-1:0];
  // push onto an empty stack writes the key straight from the input transfer
  assign wr_data     = (state_r == S_IDLE) ? in_if.key : key_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_if.cmd)
            CMD_PUSH:   state_nxt = (full || empty) ? S_RESP : S_SCAN;
            CMD_POP:    state_nxt = empty ? S_RESP : S_POP;
            CMD_SEARCH: state_nxt = empty ? S_RESP : S_SCAN;
            default:    state_nxt = S_RESP;
          endcase
        end
      end
      S_SCAN: begin
        if (hit || last) state_nxt = S_RESP;
      end
      S_POP:  state_nxt = S_RESP;
      S_RESP: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_nxt        = cnt_r;
    addr_nxt       = addr_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    res_status_nxt = res_status_r;
    res_key_nxt    = res_key_r;
    res_found_nxt  = res_found_r;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = '0;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    out_full_nxt   = out_full_r;
    out_empty_nxt  = out_empty_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_nxt        = in_if.cmd;
          key_nxt        = in_if.key;
          res_status_nxt = STAT_OK;
          res_key_nxt    = '0;
          res_found_nxt  = 1'b0;
          addr_nxt       = '0;
          case (in_if.cmd)
            CMD_PUSH: begin
              if (full) begin
                res_status_nxt = STAT_FULL;
              end else if (empty) begin
                wr_en   = 1'b1;
                cnt_nxt = cnt_r + CW'(1);
              end else begin
                rd_en = 1'b1;
              end
            end
            CMD_POP: begin
              if (empty) begin
                res_status_nxt = STAT_EMPTY;
              end else begin
                rd_en   = 1'b1;
                rd_addr = cnt_m1[AW-1:0];
              end
            end
            CMD_SEARCH: begin
              if (!empty) rd_en = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          if (cmd_r == CMD_PUSH) res_status_nxt = STAT_DUP;
          else res_found_nxt = 1'b1;
        end else if (last) begin
          if (cmd_r == CMD_PUSH) begin
            wr_en   = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end
        end else begin
          rd_en    = 1'b1;
          rd_addr  = addr_r + AW'(1);
          addr_nxt = addr_r + AW'(1);
        end
      end
      S_POP: begin
        res_key_nxt = rd_data_r;
        cnt_nxt     = cnt_m1;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_key_nxt    = res_key_r;
          out_found_nxt  = res_found_r;
          out_count_nxt  = cnt_x[COUNT_W-1:0];
          out_full_nxt   = full;
          out_empty_nxt  = empty;
        end
      end
      default: ;
    endcase
  end

  // key memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r       <= addr_nxt;
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    res_status_r <= res_status_nxt;
    res_key_r    <= res_key_nxt;
    res_found_r  <= res_found_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
    out_full_r   <= out_full_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.status   = out_status_r;
  assign out_if.key_out  = out_key_r;
  assign out_if.found    = out_found_r;
  assign out_if.count    = out_count_r;
  assign out_if.is_full  = out_full_r;
  assign out_if.is_empty = out_empty_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !full)
    else $error("memory write on a full stack");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (addr_ext < cnt_r))
    else $error("scan address beyond stored keys");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (cnt_r == $past(cnt_r)) || (cnt_r == $past(cnt_r) + CW'(1))
                     || (cnt_r == $past(cnt_r) - CW'(1)))
    else $error("stack count moved by more than one");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == STAT_EMPTY)) |-> out_empty_r)
    else $error("empty status without empty flag");

endmodule

[test/uks_result_checker.sv]
`timescale 1ns / 1ps
// uks_result_checker: watches both channels of the unique key stack, predicts each result
// from its own copy of the stack and compares every output transfer field by field
// depends on uks_pkg, uks_in_if and uks_out_if
module uks_result_checker #(
  parameter int DEPTH = uks_pkg::UKS_DEPTH
) (
  input logic clk,
  input logic rst_n,
  uks_in_if   in_ch,
  uks_out_if  out_ch,
  output int  fail_count,
  output int  results_pending,
  output int  results_checked,
  output int  full_refusals,
  output int  dup_refusals,
  output int  empty_pops,
  output int  search_hits
);
  import uks_pkg::*;

  typedef struct {
    status_t status;
    key_t    key_out;
    logic    found;
    count_t  count;
    logic    is_full;
    logic    is_empty;
  } stack_result_t;

  key_t          stack_keys[DEPTH];
  int unsigned   held = 0;
  stack_result_t expected_results[$];
  int            n_fail = 0;
  int            n_checked = 0;
  int            n_full = 0;
  int            n_dup = 0;
  int            n_empty = 0;
  int            n_hits = 0;

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    n_fail++;
  endtask

  function automatic logic key_stored(key_t k);
    for (int i = 0; i < held; i++)
      if (stack_keys[i] === k) return 1'b1;
    return 1'b0;
  endfunction

  function automatic stack_result_t stack_outcome(cmd_t op, key_t k);
    stack_result_t r;
    r.status  = STAT_OK;
    r.key_out = '0;
    r.found   = 1'b0;
    case (op)
      CMD_PUSH: begin
        // full wins over duplicate, no scan when full
        if (held >= DEPTH) begin
          r.status = STAT_FULL;
          n_full++;
        end else if (key_stored(k)) begin
          r.status = STAT_DUP;
          n_dup++;
        end else begin
          stack_keys[held] = k;
          held++;
        end
      end
      CMD_POP: begin
        if (held == 0) begin
          r.status = STAT_EMPTY;
          n_empty++;
        end else begin
          held--;
          r.key_out = stack_keys[held];
        end
      end
      CMD_SEARCH: begin
        r.found = key_stored(k);
        if (r.found) n_hits++;
      end
      default: ;
    endcase
    r.count    = count_t'(held);
    r.is_full  = (held >= DEPTH);
    r.is_empty = (held == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    stack_result_t got;
    stack_result_t want;
    if (!rst_n) begin
      held = 0;
      expected_results.delete();
    end else begin
      // older result is compared before the new transfer in is predicted
      if (out_ch.valid && out_ch.ready) begin
        got.status   = out_ch.status;
        got.key_out  = out_ch.key_out;
        got.found    = out_ch.found;
        got.count    = out_ch.count;
        got.is_full  = out_ch.is_full;
        got.is_empty = out_ch.is_empty;
        if (expected_results.size() == 0) begin
          report_mismatch("result transfer with no expectation waiting");
        end else begin
          want = expected_results.pop_front();
          n_checked++;
          if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
          if (got.key_out !== want.key_out)
            report_mismatch($sformatf("key_out got %h want %h", got.key_out, want.key_out));
          if (got.found !== want.found)
            report_mismatch($sformatf("found got %b want %b", got.found, want.found));
          if (got.count !== want.count)
            report_mismatch($sformatf("count got %0d want %0d", got.count, want.count));
          if (got.is_full !== want.is_full)
            report_mismatch($sformatf("is_full got %b want %b", got.is_full, want.is_full));
          if (got.is_empty !== want.is_empty)
            report_mismatch($sformatf("is_empty got %b want %b", got.is_empty, want.is_empty));
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_results.push_back(stack_outcome(in_ch.cmd, in_ch.key));
    end
    fail_count      <= n_fail;
    results_pending <= expected_results.size();
    results_checked <= n_checked;
    full_refusals   <= n_full;
    dup_refusals    <= n_dup;
    empty_pops      <= n_empty;
    search_hits     <= n_hits;
  end

endmodule

[test/unique_key_stack_tb.sv]
`timescale 1ns / 1ps
// unique_key_stack_tb: drives push, pop, search and unused commands into the key stack
// with random gaps and output stalls, and gives the verdict from uks_result_checker
// depends on uks_pkg, uks_in_if, uks_out_if, unique_key_stack and uks_result_checker
module unique_key_stack_tb;
  import uks_pkg::*;

  localparam int   DEPTH      = UKS_DEPTH;
  localparam cmd_t CMD_UNUSED = 2'd3;
  localparam int   NUM_ITEMS  = 950;

  logic clk;
  logic rst_n;

  uks_in_if  in_ch ();
  uks_out_if out_ch ();

  int   fail_count;
  int   results_pending;
  int   results_checked;
  int   full_refusals;
  int   dup_refusals;
  int   empty_pops;
  int   search_hits;

  int   items_sent = 0;
  int   op_tally[4] = '{0, 0, 0, 0};
  bit   send_gaps = 1'b1;
  key_t key_pool[16];

  unique_key_stack #(
    .STACK_DEPTH(DEPTH)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  uks_result_checker #(
    .DEPTH(DEPTH)
  ) checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .fail_count      (fail_count),
    .results_pending (results_pending),
    .results_checked (results_checked),
    .full_refusals   (full_refusals),
    .dup_refusals    (dup_refusals),
    .empty_pops      (empty_pops),
    .search_hits     (search_hits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // entered at a falling edge, returns at the falling edge after the transfer
  task automatic send_op(cmd_t op, key_t k);
    if (send_gaps && $urandom_range(99) < 6) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= op;
    in_ch.key   <= k;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    op_tally[op]++;
  endtask

  function automatic key_t pick_key();
    if ($urandom_range(99) < 60) return key_pool[$urandom_range(15)];
    return key_t'($urandom);
  endfunction

  // receiver: short random stalls, a quiet window, and two long hold-offs
  initial begin
    int cycle_no;
    int stall_left;
    cycle_no   = 0;
    stall_left = 0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      cycle_no++;
      if (cycle_no == 1500 || cycle_no == 20000)
        stall_left = 300;
      else if (stall_left == 0 && (cycle_no < 8000 || cycle_no > 14000) &&
               $urandom_range(99) < 6)
        stall_left = $urandom_range(8, 1);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    key_t anchor;
    int   episode;
    int   roll;
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd   = CMD_PUSH;
    in_ch.key   = '0;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < 16; i++) key_pool[i] = key_t'($urandom);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty stack, extremes, duplicate, hits and misses, drain past empty
    send_op(CMD_POP, 32'h7FFF_FFFF);
    send_op(CMD_SEARCH, 32'h8000_0000);
    send_op(CMD_UNUSED, 32'hFFFF_FFFF);
    send_op(CMD_PUSH, 32'h8000_0000);
    send_op(CMD_PUSH, 32'h7FFF_FFFF);
    send_op(CMD_PUSH, 32'h0000_0000);
    send_op(CMD_PUSH, 32'hFFFF_FFFF);
    send_op(CMD_PUSH, 32'h8000_0000);
    send_op(CMD_SEARCH, 32'h7FFF_FFFF);
    send_op(CMD_SEARCH, 32'h0000_0001);
    send_op(CMD_POP, 32'h0000_0000);
    send_op(CMD_UNUSED, 32'h0000_0000);
    send_op(CMD_PUSH, 32'h5555_5555);
    send_op(CMD_PUSH, 32'hAAAA_AAAA);
    send_op(CMD_SEARCH, 32'hAAAA_AAAA);
    send_op(CMD_SEARCH, 32'hFFFF_FFFF);
    repeat (7) send_op(CMD_POP, key_t'($urandom));

    episode = 0;
    while (items_sent < NUM_ITEMS) begin
      send_gaps = !(items_sent >= 300 && items_sent < 500);
      if (episode % 4 == 1) begin
        // fill to full, then a stored key is refused as full, then drain past empty
        anchor = pick_key();
        send_op(CMD_PUSH, anchor);
        repeat (DEPTH + 6) send_op(CMD_PUSH, key_t'($urandom));
        send_op(CMD_PUSH, anchor);
        send_op(CMD_SEARCH, anchor);
        send_op(CMD_UNUSED, anchor);
        repeat (DEPTH + 2) send_op(CMD_POP, key_t'($urandom));
      end else begin
        repeat ($urandom_range(60, 20)) begin
          roll = $urandom_range(99);
          if (roll < 40)
            send_op(CMD_PUSH, pick_key());
          else if (roll < 65)
            send_op(CMD_POP, key_t'($urandom));
          else if (roll < 95)
            send_op(CMD_SEARCH, pick_key());
          else
            send_op(CMD_UNUSED, pick_key());
        end
      end
      episode++;
    end
    in_ch.valid <= 1'b0;

    while (results_pending != 0) @(posedge clk);
    repeat (DEPTH + 16) @(posedge clk);

    $display("transfers in: %0d (push %0d, pop %0d, search %0d, unused opcode %0d)",
             items_sent, op_tally[CMD_PUSH], op_tally[CMD_POP], op_tally[CMD_SEARCH],
             op_tally[CMD_UNUSED]);
    $display("results checked: %0d (full %0d, duplicate %0d, empty pop %0d, search hits %0d)",
             results_checked, full_refusals, dup_refusals, empty_pops, search_hits);
    if (fail_count == 0 && results_pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

[unique_key_stack.f]
hdl/uks_pkg.sv
hdl/uks_if.sv
hdl/unique_key_stack.sv
test/uks_result_checker.sv
test/unique_key_stack_tb.sv
